### sv/polygon_face_normal_assert.svh
// ---------------------------------------------------------------------------
// polygon_face_normal_assert
// assertion macros for the face normal block
// ---------------------------------------------------------------------------
`ifndef POLYGON_FACE_NORMAL_ASSERT_SVH
`define POLYGON_FACE_NORMAL_ASSERT_SVH
`ifndef SYNTH
`define PFN_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define PFN_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define PFN_ASSERT(label, clk, rst_n, prop)
`define PFN_ASSERT_NR(label, clk, prop)
`endif
`endif

### sv/pfn_pkg.sv
// ---------------------------------------------------------------------------
// pfn_pkg
// shared types and constants for the face normal block
// ---------------------------------------------------------------------------
package pfn_pkg;
  localparam int MAX_POINTS_D       = 4096;
  localparam int COORD_BITS_D       = 24;
  localparam int MAX_FACE_VERTS_D   = 64;
  localparam int NORMAL_FRAC_BITS_D = 15;
  localparam int IDX_W   = 12;
  localparam int CW      = 24;
  localparam int DW      = 25;
  localparam int PW      = 50;
  localparam int SW      = 57;
  localparam int MW      = 30;
  localparam int QW      = 62;
  localparam int RW      = 31;
  localparam int OUT_W   = 16;
  localparam int VC_W    = 9;
  localparam logic [OUT_W-2:0] OUT_LIMIT = 15'h7fff;

  localparam logic OP_POINT  = 1'b0;
  localparam logic OP_VERTEX = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_VERT, ST_MUL, ST_ACC, ST_ABS, ST_SQ, ST_ROOT,
    ST_DIV, ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic [1:0] sel;
  } mul_ctl_t;
endpackage

### sv/polygon_face_normal.sv
// ---------------------------------------------------------------------------
// polygon_face_normal
// face normal from fan cross products, one shared multiplier and divider
// ---------------------------------------------------------------------------
// channel  dir  content
// in_      in   tuser: op; tdata: point_index, coord_x, coord_y, coord_z; tlast: last_of_face
// out_     out  tdata: normal_x, normal_y, normal_z; tuser: degenerate, face_overflow
// cfg_     in   flip_orientation
// a point write stays in idle; a vertex reads its point and, from the third vertex on, adds a cross product
// (six products through the shared multiplier, paired into the cross product sums)
// a face end adds abs, three squares, a bit-pair root and three divides
// a degenerate face end skips the divides
// rst_n clears control and face state; the point memory is not cleared
// a finished normal waits in the output register; a later face end stalls until it leaves
module polygon_face_normal #(
  parameter int MAX_POINTS       = pfn_pkg::MAX_POINTS_D,
  parameter int COORD_BITS       = pfn_pkg::COORD_BITS_D,
  parameter int MAX_FACE_VERTS   = pfn_pkg::MAX_FACE_VERTS_D,
  parameter int NORMAL_FRAC_BITS = pfn_pkg::NORMAL_FRAC_BITS_D
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // point_index[12], coord_x[24], coord_y[24], coord_z[24], pad
  input  logic [87:0] in_tdata,
  // op
  input  logic        in_tuser,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // normal_x, normal_y, normal_z
  output logic [47:0] out_tdata,
  // degenerate, face_overflow
  output logic [1:0]  out_tuser
);
  import pfn_pkg::*;
  localparam int AW = $clog2(MAX_POINTS);

  state_t state_r, state_nxt;
  logic flip_r;
  logic signed [CW-1:0] mem_x [MAX_POINTS];
  logic signed [CW-1:0] mem_y [MAX_POINTS];
  logic signed [CW-1:0] mem_z [MAX_POINTS];
  logic signed [CW-1:0] rd_x_r, rd_y_r, rd_z_r;
  logic [IDX_W-1:0] idx_r;
  logic last_r;
  logic signed [CW-1:0] f_r [3];
  logic signed [CW-1:0] pv_r [3];
  logic signed [SW-1:0] sum_r [3];
  logic signed [SW-1:0] cr_r;
  logic [VC_W-1:0] vc_r;
  logic ovf_r;
  logic [2:0] k_r;
  logic [SW-1:0] mag_r [3];
  logic [2:0] neg_r;
  logic [QW+1:0] q_r;
  logic [QW+1:0] n_r;
  logic [QW+1:0] rem_r;
  logic [4:0] rk_r;
  logic [OUT_W-1:0] res_r [3];
  logic obusy_r;
  logic [47:0] odata_r;
  logic [1:0] ouser_r;
  logic div_go_r;
  logic signed [CW-1:0] px, py, pz;
  logic in_acc, out_acc, in_range, in_addr_ok;
  logic [AW-1:0] in_addr;
  logic signed [MW:0] ma, mb;
  logic signed [2*MW+1:0] prod;
  logic div_done;
  logic [63:0] div_num, div_q;
  logic [RW+1:0] div_den;
  logic signed [CW-1:0] cx, cy, cz;
  logic signed [DW-1:0] ax, ay, az, bx, by, bz;
  logic signed [DW-1:0] ma0, mb0;
  logic [SW-1:0] mx;
  logic [5:0] sh;
  logic [1:0] sel3;
  logic [SW-1:0] sq_mag;
  logic [OUT_W-1:0] sat;
  logic [QW+1:0] rbit;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign out_tvalid = obusy_r;
  assign out_tdata = odata_r;
  assign out_tuser = ouser_r;
  assign in_range = ({20'b0, idx_r} < 32'(MAX_POINTS));
  assign in_addr_ok = ({20'b0, in_tdata[IDX_W-1:0]} < 32'(MAX_POINTS));
  assign in_addr = AW'(in_tdata[IDX_W-1:0]);

  function automatic logic signed [CW-1:0] take(input logic [CW-1:0] v);
    logic [CW-1:0] sx;
    sx = v << (CW - COORD_BITS);
    return $signed(sx) >>> (CW - COORD_BITS);
  endfunction

  always_ff @(posedge clk) begin
    if (in_acc && in_tuser == OP_POINT && in_addr_ok) begin
      mem_x[in_addr] <= take(in_tdata[35:12]);
      mem_y[in_addr] <= take(in_tdata[59:36]);
      mem_z[in_addr] <= take(in_tdata[83:60]);
    end
    if (in_acc) begin
      rd_x_r <= mem_x[in_addr];
      rd_y_r <= mem_y[in_addr];
      rd_z_r <= mem_z[in_addr];
    end
  end

  assign px = in_range ? rd_x_r : '0;
  assign py = in_range ? rd_y_r : '0;
  assign pz = in_range ? rd_z_r : '0;
  assign cx = pv_r[0]; assign cy = pv_r[1]; assign cz = pv_r[2];
  assign ax = DW'(cx) - DW'(f_r[0]);
  assign ay = DW'(cy) - DW'(f_r[1]);
  assign az = DW'(cz) - DW'(f_r[2]);
  assign bx = DW'(px) - DW'(f_r[0]);
  assign by = DW'(py) - DW'(f_r[1]);
  assign bz = DW'(pz) - DW'(f_r[2]);

  assign sel3 = (k_r[1:0] == 2'd3) ? 2'd0 : k_r[1:0];
  assign sq_mag = mag_r[sel3] >> sh;

  // six products: ay*bz, az*by, az*bx, ax*bz, ax*by, ay*bx
  always_comb begin
    ma0 = ay; mb0 = bz;
    case (k_r)
      3'd0: begin ma0 = ay; mb0 = bz; end
      3'd1: begin ma0 = az; mb0 = by; end
      3'd2: begin ma0 = az; mb0 = bx; end
      3'd3: begin ma0 = ax; mb0 = bz; end
      3'd4: begin ma0 = ax; mb0 = by; end
      3'd5: begin ma0 = ay; mb0 = bx; end
      default: begin ma0 = ay; mb0 = bz; end
    endcase
    ma = (MW+1)'(ma0);
    mb = (MW+1)'(mb0);
    if (state_r == ST_SQ) begin
      ma = $signed({1'b0, sq_mag[MW-1:0]});
      mb = ma;
    end
  end

  pfn_mul u_mul (.clk(clk), .a(ma), .b(mb), .p_r(prod));

  always_comb begin
    mx = mag_r[0];
    if (mag_r[1] > mx) mx = mag_r[1];
    if (mag_r[2] > mx) mx = mag_r[2];
    sh = '0;
    for (int i = 1; i <= SW - MW; i++) begin
      if ((mx >> (i - 1)) >= (SW'(1) << MW)) sh = 6'(i);
    end
  end

  assign div_num = (64'(mag_r[sel3]) << (NORMAL_FRAC_BITS + 1)) + n_r;
  assign div_den = {n_r[RW-1:0], 1'b0};
  assign sat = (div_q > 64'(OUT_LIMIT)) ? {1'b0, OUT_LIMIT} : div_q[OUT_W-1:0];

  // digit-by-digit root over q_r, bit pair at rk_r
  assign rbit = (QW+2)'(1) << {rk_r, 1'b0};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = (in_tuser == OP_POINT) ? ST_IDLE : ST_READ;
      ST_READ: state_nxt = ST_VERT;
      ST_VERT: begin
        if (vc_r >= VC_W'(MAX_FACE_VERTS) || vc_r < VC_W'(2)) state_nxt = last_r ? ST_ABS : ST_IDLE;
        else state_nxt = ST_MUL;
      end
      ST_MUL: state_nxt = ST_ACC;
      ST_ACC: state_nxt = (k_r == 3'd5) ? (last_r ? ST_ABS : ST_IDLE) : ST_MUL;
      ST_ABS: state_nxt = ST_SQ;
      ST_SQ:  state_nxt = (k_r == 3'd3) ? ST_ROOT : ST_SQ;
      ST_ROOT: begin
        if (k_r == 3'd0 && rk_r == 5'd0) state_nxt = (q_r == '0) ? ST_OUT : ST_DIV;
      end
      ST_DIV: state_nxt = (div_done && k_r == 3'd2) ? ST_OUT : ST_DIV;
      ST_OUT: state_nxt = (!obusy_r || out_tready) ? ST_IDLE : ST_OUT;
      default: state_nxt = ST_IDLE;
    endcase
  end

  pfn_div u_div (.clk(clk), .rst_n(rst_n), .start(div_go_r), .num(div_num),
                 .den(div_den), .done_r(div_done), .quo_r(div_q));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      flip_r <= 1'b0;
      obusy_r <= 1'b0;
      div_go_r <= 1'b0;
      vc_r <= '0;
      ovf_r <= 1'b0;
      k_r <= '0;
      for (int i = 0; i < 3; i++) begin
        f_r[i] <= '0; pv_r[i] <= '0; sum_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) flip_r <= cfg_wdata;
      if (state_r == ST_OUT && (!obusy_r || out_tready)) obusy_r <= 1'b1;
      else if (out_acc) obusy_r <= 1'b0;
      div_go_r <= (state_r == ST_ROOT && k_r == 3'd0 && rk_r == 5'd0 && q_r != '0)
               || (state_r == ST_DIV && div_done && k_r != 3'd2);
      case (state_r)
        ST_IDLE: if (in_acc) begin
          idx_r <= in_tdata[IDX_W-1:0];
          last_r <= in_tlast;
          k_r <= '0;
        end
        ST_VERT: begin
          if (vc_r >= VC_W'(MAX_FACE_VERTS)) ovf_r <= 1'b1;
          else begin
            if (vc_r == '0) begin
              f_r[0] <= px; f_r[1] <= py; f_r[2] <= pz;
            end
            vc_r <= vc_r + VC_W'(1);
            if (vc_r < VC_W'(2)) begin
              pv_r[0] <= px; pv_r[1] <= py; pv_r[2] <= pz;
            end
          end
          k_r <= '0;
        end
        ST_ACC: begin
          if (!k_r[0]) cr_r <= SW'(prod);
          else begin
            if (flip_r) sum_r[k_r[2:1]] <= sum_r[k_r[2:1]] - (cr_r - SW'(prod));
            else        sum_r[k_r[2:1]] <= sum_r[k_r[2:1]] + (cr_r - SW'(prod));
          end
          if (k_r == 3'd5) begin
            pv_r[0] <= px; pv_r[1] <= py; pv_r[2] <= pz;
            k_r <= '0;
          end else k_r <= k_r + 3'd1;
        end
        ST_ABS: begin
          for (int i = 0; i < 3; i++) begin
            neg_r[i] <= sum_r[i][SW-1];
            mag_r[i] <= sum_r[i][SW-1] ? SW'(-sum_r[i]) : SW'(sum_r[i]);
          end
          k_r <= '0;
          q_r <= '0;
        end
        ST_SQ: begin
          if (k_r == 3'd0) begin
            for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> sh;
          end else q_r <= q_r + (QW+2)'(prod);
          k_r <= k_r + 3'd1;
          rk_r <= 5'd31;
          n_r <= '0;
          rem_r <= '0;
        end
        ST_ROOT: begin
          if (k_r != 3'd0) begin
            rem_r <= q_r; k_r <= '0;
          end else begin
            if (rem_r >= n_r + rbit) begin
              rem_r <= rem_r - (n_r + rbit);
              n_r <= (n_r >> 1) + rbit;
            end else n_r <= n_r >> 1;
            if (rk_r != 5'd0) rk_r <= rk_r - 5'd1;
          end
        end
        ST_DIV: if (div_done) begin
          res_r[sel3] <= neg_r[sel3] ? -sat : sat;
          k_r <= k_r + 3'd1;
        end
        ST_OUT: if (!obusy_r || out_tready) begin
          odata_r <= (q_r == '0) ? 48'b0 : {res_r[2], res_r[1], res_r[0]};
          ouser_r <= {ovf_r, q_r == '0};
          vc_r <= '0; ovf_r <= 1'b0;
          for (int i = 0; i < 3; i++) begin
            f_r[i] <= '0; pv_r[i] <= '0; sum_r[i] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  `include "polygon_face_normal_assert.svh"
  `PFN_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid)
  `PFN_ASSERT(a_busy_ready, clk, rst_n, state_r != ST_IDLE |-> !in_tready)
  `PFN_ASSERT(a_vc_bound, clk, rst_n, vc_r <= VC_W'(MAX_FACE_VERTS))
endmodule

### sv/pfn_mul.sv
// ---------------------------------------------------------------------------
// pfn_mul
// shared signed multiplier with registered product
// ---------------------------------------------------------------------------
module pfn_mul (
  input  logic                                 clk,
  input  logic signed [pfn_pkg::MW:0]          a,
  input  logic signed [pfn_pkg::MW:0]          b,
  output logic signed [2*pfn_pkg::MW+1:0]      p_r
);
  import pfn_pkg::*;
  logic signed [2*MW+1:0] p_nxt;
  assign p_nxt = a * b;
  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end
endmodule

### sv/pfn_div.sv
// ---------------------------------------------------------------------------
// pfn_div
// restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module pfn_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [63:0]               num,
  input  logic [pfn_pkg::RW+1:0]    den,
  output logic                      done_r,
  output logic [63:0]               quo_r
);
  import pfn_pkg::*;
  logic [6:0]    cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [RW+2:0] rem_r, rem_nxt;
  logic [63:0]   quo_nxt;
  logic [RW+1:0] den_r;
  logic [RW+2:0] trial;
  logic          done_nxt;
  always_comb begin
    trial = {rem_r[RW+1:0], quo_r[63]};
    busy_nxt = busy_r;
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt = 7'd0;
      rem_nxt = '0;
      quo_nxt = num;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) den_r <= den;
  end
  `include "polygon_face_normal_assert.svh"
  `PFN_ASSERT(a_div_no_restart, clk, rst_n, busy_r |-> !start)
  `PFN_ASSERT(a_div_done_end, clk, rst_n, done_r |-> $past(busy_r) && !busy_r)
endmodule
